/* rtl/core/plc_pkg.sv */
// shared types and constants for the positional list engine
// word layouts for request and response, cell commands and scan records
// no dependencies
package plc_pkg;

  localparam int unsigned DEFAULT_CAPACITY = 16;
  localparam int unsigned DATA_W           = 32;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // request word
  typedef struct packed {
    logic [1:0]               req_type;
    logic [4:0]               position;
    logic signed [DATA_W-1:0] item_value;
  } req_word_t;

  // response word
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [4:0]               found_position;
    logic [4:0]               entry_count;
  } rsp_word_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  // broadcast to all cells
  typedef struct packed {
    cell_op_e          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // record that walks down the chain during find and read
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [DATA_W-1:0] data;
  } scan_rec_t;

endpackage

/* rtl/core/plc_cell.sv */
// one storage cell of the list chain: holds one entry, shifts with its
// neighbors on insert and remove, and updates the passing scan record
// depends on plc_pkg
module plc_cell #(
  parameter int unsigned CAPACITY = plc_pkg::DEFAULT_CAPACITY,
  parameter int unsigned IDX      = 0,
  localparam int unsigned IW      = $clog2(CAPACITY),
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plc_pkg::cell_cmd_t                cmd_i,
  input  logic [IW-1:0]                     sel_idx_i,
  input  logic [CW-1:0]                     count_i,
  input  logic [plc_pkg::DATA_W-1:0]        left_entry_i,
  input  logic [plc_pkg::DATA_W-1:0]        right_entry_i,
  output logic [plc_pkg::DATA_W-1:0]        entry_o,
  input  plc_pkg::scan_rec_t                scan_i,
  input  logic [CW-1:0]                     scan_pos_i,
  output plc_pkg::scan_rec_t                scan_o,
  output logic [CW-1:0]                     scan_pos_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX + 1);

  logic [plc_pkg::DATA_W-1:0] entry_q, entry_d;
  plc_pkg::scan_rec_t         scan_q, scan_d;
  logic [CW-1:0]              pos_q, pos_d;
  logic                       match;

  // entry shift
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      plc_pkg::CELL_INSERT: begin
        if (MY_IDX > sel_idx_i) begin
          entry_d = left_entry_i;
        end else if (MY_IDX == sel_idx_i) begin
          entry_d = cmd_i.value;
        end
      end
      plc_pkg::CELL_REMOVE: begin
        if (MY_IDX >= sel_idx_i) begin
          entry_d = right_entry_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // scan record update: first live match and selected read data
  assign match = (count_i > CW'(IDX)) && (entry_q == cmd_i.value);

  always_comb begin
    scan_d.valid = scan_i.valid;
    scan_d.hit   = scan_i.hit | match;
    pos_d        = scan_i.hit ? scan_pos_i : MY_POS;
    scan_d.data  = (MY_IDX == sel_idx_i) ? entry_q : scan_i.data;
  end

  // scan record register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      pos_q  <= '0;
    end else begin
      scan_q <= scan_d;
      pos_q  <= pos_d;
    end
  end

  assign entry_o    = entry_q;
  assign scan_o     = scan_q;
  assign scan_pos_o = pos_q;

endmodule

/* rtl/core/positional_list_engine_unit.sv */
// Positional list engine: a chain of CAPACITY cells, one entry each.
// Insert, remove and a read with a bad position: result in the output
// register in the cycle after acceptance. Find and in-range read: the scan
// record walks the chain of cell registers into the output register.
// One request in flight; the next is taken once its word is delivered.
// Reset clears the entry count and all valid flags; entries are not reset.
module positional_list_engine_unit #(
  parameter int unsigned CAPACITY = plc_pkg::DEFAULT_CAPACITY
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plc_pkg::req_word_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output plc_pkg::rsp_word_t out_data_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;
  localparam int unsigned DW = plc_pkg::DATA_W;

  logic               busy_q, busy_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q, out_valid_d;
  plc_pkg::rsp_word_t out_q, out_d;
  logic               find_q, find_d;
  logic [DW-1:0]      key_q, key_d;
  logic [IW-1:0]      sel_q, sel_d;

  logic               accept, out_free, launch, load_imm, load_scan;
  logic [PW-1:0]      pos_ext, cnt_ext;
  logic               pos_zero, ins_bad, full, idx_bad;
  logic [IW-1:0]      in_idx, sel_idx;
  plc_pkg::cell_cmd_t cmd;
  logic [1:0]         imm_status;

  logic [DW-1:0]      entry_w [CAPACITY];
  plc_pkg::scan_rec_t scan_w  [CAPACITY+1];
  logic [CW-1:0]      pos_w   [CAPACITY+1];

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // position checks
  assign pos_ext  = PW'(in_data_i.position);
  assign cnt_ext  = PW'(count_q);
  assign pos_zero = (in_data_i.position == 5'd0);
  assign ins_bad  = pos_zero || (pos_ext > cnt_ext + PW'(1));
  assign idx_bad  = pos_zero || (pos_ext > cnt_ext);
  assign full     = (cnt_ext == PW'(CAPACITY));
  assign in_idx   = IW'(pos_ext - PW'(1));

  // request decode
  always_comb begin
    cmd.op     = plc_pkg::CELL_HOLD;
    cmd.value  = accept ? DW'(in_data_i.item_value) : key_q;
    count_d    = count_q;
    launch     = 1'b0;
    imm_status = plc_pkg::ST_OK;
    if (accept) begin
      case (in_data_i.req_type)
        plc_pkg::REQ_INSERT: begin
          if (ins_bad) begin
            imm_status = plc_pkg::ST_BOUNDS;
          end else if (full) begin
            imm_status = plc_pkg::ST_FULL;
          end else begin
            cmd.op  = plc_pkg::CELL_INSERT;
            count_d = count_q + CW'(1);
          end
        end
        plc_pkg::REQ_REMOVE: begin
          if (idx_bad) begin
            imm_status = plc_pkg::ST_BOUNDS;
          end else begin
            cmd.op  = plc_pkg::CELL_REMOVE;
            count_d = count_q - CW'(1);
          end
        end
        plc_pkg::REQ_FIND: begin
          launch = 1'b1;
        end
        plc_pkg::REQ_READ: begin
          if (idx_bad) begin
            imm_status = plc_pkg::ST_BOUNDS;
          end else begin
            launch = 1'b1;
          end
        end
        default: imm_status = plc_pkg::ST_OK;
      endcase
    end
  end

  assign sel_idx = accept ? in_idx : sel_q;

  // pending scan request
  always_comb begin
    find_d = find_q;
    key_d  = key_q;
    sel_d  = sel_q;
    if (launch) begin
      find_d = (in_data_i.req_type == plc_pkg::REQ_FIND);
      key_d  = DW'(in_data_i.item_value);
      sel_d  = in_idx;
    end
  end

  // cell chain
  assign scan_w[0].valid = launch;
  assign scan_w[0].hit   = 1'b0;
  assign scan_w[0].data  = '0;
  assign pos_w[0]        = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DW-1:0] left_entry, right_entry;
    if (g == 0) begin : g_first
      assign left_entry = cmd.value;
    end else begin : g_mid
      assign left_entry = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entry_w[g+1];
    end
    plc_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .sel_idx_i     (sel_idx),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[g]),
      .scan_i        (scan_w[g]),
      .scan_pos_i    (pos_w[g]),
      .scan_o        (scan_w[g+1]),
      .scan_pos_o    (pos_w[g+1])
    );
  end

  // result word
  assign load_imm  = accept && !launch;
  assign load_scan = scan_w[CAPACITY].valid;

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (launch) begin
      busy_d = 1'b1;
    end
    if (load_imm) begin
      out_valid_d          = 1'b1;
      out_d.status         = imm_status;
      out_d.read_value     = '0;
      out_d.found_position = 5'd0;
      out_d.entry_count    = 5'(count_d);
    end else if (load_scan) begin
      busy_d               = 1'b0;
      out_valid_d          = 1'b1;
      out_d.status         = plc_pkg::ST_OK;
      out_d.read_value     = find_q ? '0 : scan_w[CAPACITY].data;
      out_d.found_position = (find_q && scan_w[CAPACITY].hit) ? 5'(pos_w[CAPACITY]) : 5'd0;
      out_d.entry_count    = 5'(count_q);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    find_q <= find_d;
    key_q  <= key_d;
    sel_q  <= sel_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a scan in flight never overlaps a pending result word
  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("result word pending while scan in flight");

  // a scan record only leaves the chain while a scan is pending
  a_scan_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_w[CAPACITY].valid |-> busy_q)
    else $error("scan record without pending request");

  // entry count stays within capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // the count only moves on an accepted request
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count changed without a request");
`endif

endmodule
